[src/pba_pkg.sv]
// Shared types, codes and the bend table for the pitch-bend arpeggiator.
package pba_pkg;

  localparam int unsigned FRAME_BITS = 16;
  localparam int unsigned TIME_BITS  = 64;
  localparam int unsigned DUR_BITS   = 24;
  localparam int unsigned BEND_BITS  = 15;

  localparam logic OP_MIDI      = 1'b0;
  localparam logic OP_BLOCK_END = 1'b1;

  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_BEND  = 1'b1;

  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
  localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
  localparam logic [7:0] STATUS_BEND     = 8'hE0;

  localparam logic REG_DURATION = 1'b0;
  localparam logic REG_PATTERN  = 1'b1;

  localparam logic [DUR_BITS-1:0] DURATION_RESET = 24'd12000;
  localparam logic [7:0]          PATTERN_RESET  = 8'h37;

  typedef struct packed {
    logic                  op;
    logic [FRAME_BITS-1:0] frame;
    logic [7:0]            status_byte;
    logic [7:0]            data_one;
    logic [7:0]            data_two;
  } in_item_t;

  typedef struct packed {
    logic                  kind;
    logic [FRAME_BITS-1:0] out_frame;
    logic [7:0]            byte_zero;
    logic [7:0]            byte_one;
    logic [7:0]            byte_two;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    logic     is_note;
  } q_entry_t;

  typedef struct packed {
    logic [DUR_BITS-1:0] step_duration_total;
    logic [7:0]          step_pattern;
  } cfg_t;

  // 0x2000 + offset * 0x1FFF / 12 for each 4-bit offset
  function automatic logic [BEND_BITS-1:0] bend_value(input logic [3:0] offset);
    logic [BEND_BITS-1:0] val;
    case (offset)
      4'd0:    val = 15'd8192;
      4'd1:    val = 15'd8874;
      4'd2:    val = 15'd9557;
      4'd3:    val = 15'd10239;
      4'd4:    val = 15'd10922;
      4'd5:    val = 15'd11604;
      4'd6:    val = 15'd12287;
      4'd7:    val = 15'd12970;
      4'd8:    val = 15'd13652;
      4'd9:    val = 15'd14335;
      4'd10:   val = 15'd15017;
      4'd11:   val = 15'd15700;
      4'd12:   val = 15'd16383;
      4'd13:   val = 15'd17065;
      4'd14:   val = 15'd17748;
      default: val = 15'd18430;
    endcase
    return val;
  endfunction

endpackage

[src/pitch_bend_arpeggiator_top.sv]
// Top level of the pitch-bend arpeggiator: register file, front queue and back end.
// Each input item passes through the back end as a load (overlapped with the previous item's
// final step), four steps, each one 64-bit add of the step time and a window compare, and
// a final step that forwards the event or releases the held last bend; a step with a result
// waits while the output is busy, and a two-entry queue in front takes items during that work.
// An item gives up to five results, one per transfer; a block end with no bend due gives none.
module pitch_bend_arpeggiator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pba_pkg::in_item_t   in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pba_pkg::out_item_t  out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import pba_pkg::*;

  cfg_t     cfg;
  logic     q_valid;
  logic     q_pop;
  q_entry_t q_entry;

  pba_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pba_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  pba_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

[src/pba_cfg.sv]
// APB register file holding the arpeggio length and step pattern.
module pba_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output pba_pkg::cfg_t      cfg_o
);
  import pba_pkg::*;

  logic [DUR_BITS-1:0] dur_q, dur_d;
  logic [7:0]          pat_q, pat_d;
  logic                wr_en;
  logic                reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    dur_d = dur_q;
    pat_d = pat_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_DURATION: dur_d = pwdata[DUR_BITS-1:0];
        REG_PATTERN:  pat_d = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DURATION: prdata = {{(32-DUR_BITS){1'b0}}, dur_q};
      REG_PATTERN:  prdata = {24'd0, pat_q};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q <= DURATION_RESET;
      pat_q <= PATTERN_RESET;
    end else begin
      dur_q <= dur_d;
      pat_q <= pat_d;
    end
  end

  assign cfg_o.step_duration_total = dur_q;
  assign cfg_o.step_pattern        = pat_q;

endmodule

[src/pba_front.sv]
// Front end: accepts input items, marks note events and queues them for the back end.
module pba_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pba_pkg::in_item_t   in_i,
  output logic                q_valid_o,
  output pba_pkg::q_entry_t   q_entry_o,
  input  logic                q_pop_i
);
  import pba_pkg::*;

  q_entry_t   fifo_q [2];
  q_entry_t   new_entry;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign in_ready_o = (count_q != 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_entry_o  = fifo_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = q_pop_i && q_valid_o;

  // note on and note off retrigger; other MIDI events are only forwarded
  always_comb begin
    new_entry.item    = in_i;
    new_entry.is_note = (in_i.op == OP_MIDI) &&
                        ((in_i.status_byte[7:4] == STATUS_NOTE_OFF) ||
                         (in_i.status_byte[7:4] == STATUS_NOTE_ON));
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_entry;
    end
  end

endmodule

[src/pba_back.sv]
// Back end: keeps time and arpeggio state, emits bends of each window and forwards events.
module pba_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pba_pkg::cfg_t       cfg_i,
  input  logic                q_valid_i,
  input  pba_pkg::q_entry_t   q_entry_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pba_pkg::out_item_t  out_o
);
  import pba_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_STEP  = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [1:0] step_q, step_d;

  // time and arpeggio state
  logic [TIME_BITS-1:0]  bs_q, bs_d;
  logic [FRAME_BITS-1:0] wb_q, wb_d;
  logic                  arp_active_q, arp_active_d;
  logic [TIME_BITS-1:0]  arp_start_q, arp_start_d;
  logic [DUR_BITS-1:0]   ofs1_q, ofs2_q, ofs3_q;
  logic [DUR_BITS-1:0]   ofs1_d, ofs2_d, ofs3_d;
  logic [7:0]            arp_pat_q, arp_pat_d;

  // item at work
  q_entry_t              w_q;
  logic [TIME_BITS-1:0]  from_q, until_q;
  logic [FRAME_BITS-1:0] bs_lo_q;
  logic [TIME_BITS-1:0]  from_new, until_new;

  // held bend of a block end, released once its last flag is known
  logic       hold_valid_q, hold_valid_d;
  out_item_t  hold_q;

  logic       out_valid_q, out_valid_d;
  out_item_t  out_q;

  logic                  push_ok, push, step_adv, final_done, hold_set, load;
  out_item_t             push_item, bend_item, fwd_item, hold_last;
  logic [DUR_BITS-1:0]   step_ofs;
  logic [TIME_BITS-1:0]  step_t;
  logic                  hit;
  logic [3:0]            nib;
  logic [BEND_BITS-1:0]  bend;
  logic [DUR_BITS+1:0]   dur3;

  assign push_ok = !out_valid_q || out_ready_i;

  always_comb begin
    case (step_q)
      2'd1:    begin step_ofs = ofs1_q; nib = arp_pat_q[7:4]; end
      2'd2:    begin step_ofs = ofs2_q; nib = arp_pat_q[3:0]; end
      2'd3:    begin step_ofs = ofs3_q; nib = 4'd0;           end
      default: begin step_ofs = '0;     nib = 4'd0;           end
    endcase
  end

  assign step_t = arp_start_q + TIME_BITS'(step_ofs);
  assign hit    = arp_active_q && (step_t >= from_q) && (step_t < until_q);
  assign bend   = bend_value(nib);

  always_comb begin
    bend_item.kind      = KIND_BEND;
    bend_item.out_frame = step_t[FRAME_BITS-1:0] - bs_lo_q;
    bend_item.byte_zero = STATUS_BEND;
    bend_item.byte_one  = {1'b0, bend[6:0]};
    bend_item.byte_two  = {1'b0, bend[13:7]};
    bend_item.last      = 1'b0;

    fwd_item.kind      = KIND_EVENT;
    fwd_item.out_frame = w_q.item.frame;
    fwd_item.byte_zero = w_q.item.status_byte;
    fwd_item.byte_one  = w_q.item.data_one;
    fwd_item.byte_two  = w_q.item.data_two;
    fwd_item.last      = 1'b1;

    hold_last      = hold_q;
    hold_last.last = 1'b1;
  end

  always_comb begin
    push       = 1'b0;
    push_item  = bend_item;
    step_adv   = 1'b0;
    final_done = 1'b0;
    hold_set   = 1'b0;
    hold_valid_d = hold_valid_q;
    unique case (phase_q)
      PH_STEP: begin
        if (!hit) begin
          step_adv = 1'b1;
        end else if (w_q.item.op == OP_MIDI) begin
          // the forwarded event comes last, so bends go out directly
          if (push_ok) begin
            push     = 1'b1;
            step_adv = 1'b1;
          end
        end else if (!hold_valid_q) begin
          hold_set = 1'b1;
          step_adv = 1'b1;
        end else if (push_ok) begin
          push      = 1'b1;
          push_item = hold_q;
          hold_set  = 1'b1;
          step_adv  = 1'b1;
        end
      end
      PH_FINAL: begin
        if (w_q.item.op == OP_MIDI) begin
          push_item = fwd_item;
          if (push_ok) begin
            push       = 1'b1;
            final_done = 1'b1;
          end
        end else if (hold_valid_q) begin
          push_item = hold_last;
          if (push_ok) begin
            push         = 1'b1;
            final_done   = 1'b1;
            hold_valid_d = 1'b0;
          end
        end else begin
          final_done = 1'b1;
        end
      end
      default: ;
    endcase
    if (hold_set) begin
      hold_valid_d = 1'b1;
    end
  end

  // the next item loads while the current one finishes
  assign load    = q_valid_i && ((phase_q == PH_IDLE) || final_done);
  assign q_pop_o = load;

  assign from_new  = bs_q + TIME_BITS'(wb_q);
  assign until_new = bs_q + TIME_BITS'(q_entry_i.item.frame);
  assign dur3      = {2'b00, cfg_i.step_duration_total} +
                     {1'b0, cfg_i.step_duration_total, 1'b0};

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    if (load) begin
      phase_d = PH_STEP;
      step_d  = 2'd0;
    end else if (final_done) begin
      phase_d = PH_IDLE;
    end else if ((phase_q == PH_STEP) && step_adv) begin
      if (step_q == 2'd3) begin
        phase_d = PH_FINAL;
      end else begin
        step_d = step_q + 2'd1;
      end
    end
  end

  always_comb begin
    bs_d = bs_q;
    wb_d = wb_q;
    if (load) begin
      if (q_entry_i.item.op == OP_MIDI) begin
        wb_d = q_entry_i.item.frame;
      end else begin
        bs_d = until_new;
        wb_d = '0;
      end
    end
  end

  // retrigger: the event's absolute time is the window end computed at load
  always_comb begin
    arp_active_d = arp_active_q;
    arp_start_d  = arp_start_q;
    ofs1_d       = ofs1_q;
    ofs2_d       = ofs2_q;
    ofs3_d       = ofs3_q;
    arp_pat_d    = arp_pat_q;
    if (final_done && w_q.is_note) begin
      arp_active_d = 1'b1;
      arp_start_d  = until_q;
      ofs1_d       = {2'b00, cfg_i.step_duration_total[DUR_BITS-1:2]};
      ofs2_d       = {1'b0, cfg_i.step_duration_total[DUR_BITS-1:1]};
      ofs3_d       = dur3[DUR_BITS+1:2];
      arp_pat_d    = cfg_i.step_pattern;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      step_q       <= 2'd0;
      bs_q         <= '0;
      wb_q         <= '0;
      arp_active_q <= 1'b0;
      arp_start_q  <= '0;
      ofs1_q       <= '0;
      ofs2_q       <= '0;
      ofs3_q       <= '0;
      arp_pat_q    <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      step_q       <= step_d;
      bs_q         <= bs_d;
      wb_q         <= wb_d;
      arp_active_q <= arp_active_d;
      arp_start_q  <= arp_start_d;
      ofs1_q       <= ofs1_d;
      ofs2_q       <= ofs2_d;
      ofs3_q       <= ofs3_d;
      arp_pat_q    <= arp_pat_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      w_q     <= q_entry_i;
      from_q  <= from_new;
      until_q <= until_new;
      bs_lo_q <= bs_q[FRAME_BITS-1:0];
    end
    if (hold_set) begin
      hold_q <= bend_item;
    end
    if (push) begin
      out_q <= push_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[src/pba_checker.sv]
// Port-level checker for the pitch-bend arpeggiator, bound to the top level.
module pba_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input pba_pkg::out_item_t out_o
);
  import pba_pkg::*;

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_o))
    else $error("stalled result changed");

  // after reset the queue accepts input and the output register is empty
  assert property (@(posedge clk_i)
    !rst_ni |=> in_ready_o && !out_valid_o)
    else $error("block not empty in reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.kind == KIND_BEND) |->
      (out_o.byte_zero == STATUS_BEND) && !out_o.byte_one[7] && !out_o.byte_two[7])
    else $error("malformed pitch bend");

endmodule

bind pitch_bend_arpeggiator_top pba_checker u_pba_checker (.*);

[dv/pitch_bend_arpeggiator_top_tb.sv]
// Self-checking testbench for the pitch-bend arpeggiator: timed MIDI stream in, bends and events out.
module pitch_bend_arpeggiator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pba_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_MSGS      = 5;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_i        = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  pitch_bend_arpeggiator_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_item_t    events_to_send[$];
  out_item_t   msgs_due[$];
  int unsigned items_queued   = 0;
  int unsigned send_gap_pct   = 28;
  int unsigned sink_stall_pct = 28;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;

  // Arpeggiator shadow state
  logic [DUR_BITS-1:0]   cfg_duration = DURATION_RESET;
  logic [7:0]            cfg_pattern  = PATTERN_RESET;
  logic [TIME_BITS-1:0]  block_origin = '0;
  logic [FRAME_BITS-1:0] window_lo    = '0;
  logic                  arp_running  = 1'b0;
  logic [TIME_BITS-1:0]  arp_origin   = '0;
  logic [DUR_BITS-1:0]   arp_span     = '0;
  logic [7:0]            arp_steps    = '0;

  function automatic out_item_t bend_msg(input logic [TIME_BITS-1:0] rel,
                                         input logic [3:0] semis);
    int unsigned amount;
    out_item_t   m;
    amount      = 32'h2000 + (int'(semis) * 32'h1FFF) / 12;
    m.kind      = KIND_BEND;
    m.out_frame = rel[FRAME_BITS-1:0];
    m.byte_zero = STATUS_BEND;
    m.byte_one  = {1'b0, amount[6:0]};
    m.byte_two  = {1'b0, amount[13:7]};
    m.last      = 1'b0;
    return m;
  endfunction

  // Emit the bends due in the open window, then forward or advance time.
  function automatic void advance_arpeggio(input in_item_t it);
    out_item_t            burst[MAX_MSGS];
    int                   n;
    logic [TIME_BITS-1:0] lo_abs;
    logic [TIME_BITS-1:0] hi_abs;
    logic [TIME_BITS-1:0] step_at;
    logic [3:0]           semis;
    out_item_t            fwd;
    n      = 0;
    lo_abs = block_origin + TIME_BITS'(window_lo);
    hi_abs = block_origin + TIME_BITS'(it.frame);
    if (arp_running) begin
      for (int i = 0; i < 4; i++) begin
        step_at = arp_origin + (TIME_BITS'(i) * TIME_BITS'(arp_span)) / 4;
        if (lo_abs <= step_at && step_at < hi_abs) begin
          semis = (i == 1) ? arp_steps[7:4] : (i == 2) ? arp_steps[3:0] : 4'd0;
          burst[n] = bend_msg(step_at - block_origin, semis);
          n++;
        end
      end
    end
    if (it.op == OP_MIDI) begin
      window_lo     = it.frame;
      fwd.kind      = KIND_EVENT;
      fwd.out_frame = it.frame;
      fwd.byte_zero = it.status_byte;
      fwd.byte_one  = it.data_one;
      fwd.byte_two  = it.data_two;
      fwd.last      = 1'b0;
      burst[n]      = fwd;
      n++;
      if (it.status_byte[7:4] == STATUS_NOTE_OFF || it.status_byte[7:4] == STATUS_NOTE_ON) begin
        arp_running = 1'b1;
        arp_origin  = block_origin + TIME_BITS'(it.frame);
        arp_span    = cfg_duration;
        arp_steps   = cfg_pattern;
      end
    end else begin
      block_origin = block_origin + TIME_BITS'(it.frame);
      window_lo    = '0;
    end
    if (n > 0) burst[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) msgs_due.push_back(burst[k]);
  endfunction

  always @(posedge clk_i) begin : event_driver
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) advance_arpeggio(in_i);
      if (!in_valid_i || in_ready_o) begin
        if (events_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_i       <= events_to_send.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : msg_monitor
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (msgs_due.size() == 0) begin
          if (mismatches < 10) $display("unexpected message %p", out_o);
          mismatches++;
        end else begin
          want = msgs_due.pop_front();
          if (out_o.kind !== want.kind || out_o.out_frame !== want.out_frame ||
              out_o.byte_zero !== want.byte_zero || out_o.byte_one !== want.byte_one ||
              out_o.byte_two !== want.byte_two || out_o.last !== want.last) begin
            if (mismatches < 10) begin
              $display("message mismatch: expected kind %0d frame %0d bytes %h %h %h last %0d",
                       want.kind, want.out_frame, want.byte_zero, want.byte_one,
                       want.byte_two, want.last);
              $display("                  got      kind %0d frame %0d bytes %h %h %h last %0d",
                       out_o.kind, out_o.out_frame, out_o.byte_zero, out_o.byte_one,
                       out_o.byte_two, out_o.last);
            end
            mismatches++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_DURATION) cfg_duration = value[DUR_BITS-1:0];
    else cfg_pattern = value[7:0];
  endtask

  task automatic queue_midi(input int unsigned frm, input logic [7:0] st,
                            input logic [7:0] d1, input logic [7:0] d2);
    in_item_t it;
    it.op          = OP_MIDI;
    it.frame       = frm[FRAME_BITS-1:0];
    it.status_byte = st;
    it.data_one    = d1;
    it.data_two    = d2;
    events_to_send.push_back(it);
    items_queued++;
  endtask

  task automatic queue_block_end(input int unsigned len);
    in_item_t it;
    it.op          = OP_BLOCK_END;
    it.frame       = len[FRAME_BITS-1:0];
    it.status_byte = 8'($urandom);
    it.data_one    = 8'($urandom);
    it.data_two    = 8'($urandom);
    events_to_send.push_back(it);
    items_queued++;
  endtask

  // One processing block: mostly ordered events, mostly notes, usually closed by its block end.
  task automatic queue_random_block();
    int unsigned blen;
    int unsigned n_ev;
    int unsigned pos;
    int unsigned frm;
    logic [3:0]  hi_nib;
    logic [7:0]  st;
    blen = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(1, 3000);
    n_ev = $urandom_range(5);
    pos  = 0;
    for (int e = 0; e < n_ev; e++) begin
      if ($urandom_range(9) == 0) begin
        frm = $urandom_range(65535);
      end else begin
        pos = pos + $urandom_range(blen / (n_ev + 1));
        frm = pos;
      end
      hi_nib = $urandom_range(1) ? STATUS_NOTE_ON : STATUS_NOTE_OFF;
      st     = ($urandom_range(99) < 60) ? {hi_nib, 4'($urandom)} : 8'($urandom);
      queue_midi(frm, st, 8'($urandom), 8'($urandom));
    end
    // drop the block end now and then so events run on into the next block
    if ($urandom_range(19) != 0) queue_block_end(blen);
  endtask

  task automatic wait_quiet();
    while (events_to_send.size() != 0 || in_valid_i || msgs_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned start;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: no arpeggio yet, then retrigger, out-of-order and extreme frames
    queue_midi(0, 8'h00, 8'h00, 8'h00);
    queue_midi(10, 8'hFF, 8'hFF, 8'hFF);
    queue_block_end(0);
    queue_midi(0, {STATUS_NOTE_ON, 4'h0}, 8'd60, 8'd100);
    queue_midi(4000, 8'hB0, 8'h01, 8'h02);
    queue_block_end(5000);
    queue_midi(3000, {STATUS_NOTE_OFF, 4'h0}, 8'd60, 8'h00);
    queue_midi(1000, 8'hA0, 8'h7F, 8'h80);
    queue_block_end(65535);
    queue_midi(65535, {STATUS_NOTE_ON, 4'hF}, 8'hFF, 8'hFF);
    queue_midi(100, 8'h7F, 8'h55, 8'hAA);
    queue_block_end(65535);
    wait_quiet();

    // zero duration stacks all steps on one frame; large offsets wrap the bend
    write_reg(REG_DURATION, 32'd0);
    write_reg(REG_PATTERN, 32'h0000_00FF);
    queue_midi(100, {STATUS_NOTE_OFF, 4'hF}, 8'h00, 8'h7F);
    queue_midi(101, 8'hE0, 8'h12, 8'h34);
    queue_block_end(200);
    wait_quiet();

    write_reg(REG_DURATION, 32'hFFFF_FFFF);
    write_reg(REG_PATTERN, 32'hFFFF_FF00);
    queue_midi(0, {STATUS_NOTE_ON, 4'h3}, 8'd64, 8'd1);
    queue_block_end(65535);
    queue_block_end(65535);
    wait_quiet();

    write_reg(REG_DURATION, 32'd1);
    write_reg(REG_PATTERN, 32'h0000_00C0);
    queue_midi(7, {STATUS_NOTE_ON, 4'h9}, 8'h3C, 8'h40);
    queue_midi(8, 8'hD0, 8'h11, 8'h22);
    queue_block_end(8);

    for (int ph = 0; ph < 5; ph++) begin
      wait_quiet();
      write_reg(REG_DURATION, (ph == 4) ? $urandom_range(1, 16777215) : $urandom_range(1, 3000));
      write_reg(REG_PATTERN, $urandom_range(255));
      send_gap_pct   = (ph == 2) ? 0 : 28;
      sink_stall_pct = (ph == 2) ? 0 : 28;
      start = items_queued;
      while (items_queued - start < 36) queue_random_block();
    end
    wait_quiet();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
